// ===== hw/rtl/rbst_pkg.sv =====
package rbst_pkg;

    localparam int unsigned QW        = 32;            // Q16.16 word
    localparam int unsigned FRAC_W    = 16;
    localparam int unsigned AXES      = 3;
    localparam int unsigned LANES     = 2 * AXES;      // one divider lane per slab plane
    localparam int unsigned DIFF_W    = QW + 1;        // exact corner - origin
    localparam int unsigned NUM_W     = DIFF_W + FRAC_W; // scaled numerator magnitude
    localparam int unsigned DIV_STEPS = NUM_W;         // one quotient bit per stage
    localparam int unsigned IN_FIELDS = 12;
    localparam int unsigned IN_W      = IN_FIELDS * QW;
    localparam int unsigned DIST_W    = 31;
    localparam int unsigned OUT_W     = 32;

    localparam logic signed [QW-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] Q_MIN = 32'sh8000_0000;

    // field slots in the input item
    localparam int unsigned F_ORIGIN = 0;
    localparam int unsigned F_DIR    = 3;
    localparam int unsigned F_MIN    = 6;
    localparam int unsigned F_MAX    = 9;

    typedef logic signed [QW-1:0] q_t;

    // saturate a truncated magnitude quotient to the signed Q16.16 range
    function automatic q_t sat_quot(input logic [NUM_W-1:0] mag, input logic neg);
        q_t res;
        if (!neg) begin
            res = (mag > NUM_W'(33'h0_7FFF_FFFF)) ? Q_MAX : q_t'(mag[QW-1:0]);
        end else begin
            res = (mag > NUM_W'(33'h0_8000_0000)) ? Q_MIN : q_t'(-mag[QW-1:0]);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/ray_box_slab_test.sv =====
// Channel | Dir | Fields
// s_axis  | in  | tdata: origin_x/y/z, direction_x/y/z, box_min_x/y/z, box_max_x/y/z
// m_axis  | out | tdata: entry_distance; tuser: hit
//
// One item per cycle while s_axis_tready is high; the 49-stage restoring
// divider gives one quotient bit per stage, six lanes side by side.
// aresetn clears all valid bits; payload registers are not reset.
// An output skid stage catches a result that arrives while the output stalls;
// s_axis_tready is then dropped until the skid stage drains.
module ray_box_slab_test
    import rbst_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [IN_W-1:0]    s_axis_tdata,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [OUT_W-1:0]   m_axis_tdata,   // entry_distance[30:0], zero pad
    output logic               m_axis_tuser    // hit
);

    typedef struct packed {
        logic            valid;
        logic [AXES-1:0] par;
        logic            par_miss;
    } side_t;

    logic ce;

    // divider pipeline, index 0 is the operand stage
    logic [QW-1:0]    rem_reg  [DIV_STEPS+1][LANES];
    logic [NUM_W-1:0] nq_reg   [DIV_STEPS+1][LANES];
    logic [QW-1:0]    den_reg  [DIV_STEPS+1][LANES];
    logic             neg_reg  [DIV_STEPS+1][LANES];
    side_t            side_reg [DIV_STEPS+1];

    // result of divider step k, loaded into stage k+1
    logic [QW-1:0]    rem_next [DIV_STEPS][LANES];
    logic [NUM_W-1:0] nq_next  [DIV_STEPS][LANES];
    logic [NUM_W-1:0] nq0_next [LANES];
    logic             neg_next [LANES];
    logic [QW-1:0]    den_next [LANES];
    side_t            side0_next;

    // post-divide stages
    q_t    t_reg    [LANES];
    side_t tside_reg;
    q_t    tmin_reg [AXES];
    q_t    tmax_reg [AXES];
    side_t oside_reg;
    q_t    near_reg;
    q_t    far_reg;
    side_t mside_reg;

    logic              out_v_reg, skid_v_reg;
    logic              out_hit_reg, skid_hit_reg;
    logic [DIST_W-1:0] out_dist_reg, skid_dist_reg;

    logic              res_hit;
    logic [DIST_W-1:0] res_dist;
    q_t                near_next, far_next;

    assign ce            = !skid_v_reg;
    assign s_axis_tready = ce;

    // operand stage: exact differences, magnitudes and signs
    always_comb begin
        logic signed [QW-1:0]     o, c, d, lo, hi;
        logic signed [DIFF_W-1:0] diff;
        logic [DIFF_W-1:0]        dmag;
        int                       a;
        side0_next.valid    = s_axis_tvalid;
        side0_next.par      = '0;
        side0_next.par_miss = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            a  = (l < AXES) ? l : l - AXES;
            o  = s_axis_tdata[(F_ORIGIN + a) * QW +: QW];
            d  = s_axis_tdata[(F_DIR + a) * QW +: QW];
            lo = s_axis_tdata[(F_MIN + a) * QW +: QW];
            hi = s_axis_tdata[(F_MAX + a) * QW +: QW];
            c  = (l < AXES) ? lo : hi;
            diff = {c[QW-1], c} - {o[QW-1], o};
            dmag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
            nq0_next[l]  = {dmag, {FRAC_W{1'b0}}};
            den_next[l]  = d[QW-1] ? QW'(-d) : QW'(d);
            neg_next[l]  = diff[DIFF_W-1] ^ d[QW-1];
            if (l < AXES) begin
                side0_next.par[a] = (d == '0);
                if (d == '0 && (o < lo || o > hi)) begin
                    side0_next.par_miss = 1'b1;
                end
            end
        end
    end

    // one restoring step per stage and lane
    always_comb begin
        logic [QW:0] rs, rn;
        logic        ge;
        for (int k = 0; k < DIV_STEPS; k++) begin
            for (int l = 0; l < LANES; l++) begin
                rs = {rem_reg[k][l], nq_reg[k][l][NUM_W-1]};
                ge = rs >= {1'b0, den_reg[k][l]};
                rn = ge ? rs - {1'b0, den_reg[k][l]} : rs;
                rem_next[k][l] = rn[QW-1:0];
                nq_next[k][l]  = {nq_reg[k][l][NUM_W-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < LANES; l++) begin
                rem_reg[0][l] <= '0;
                nq_reg[0][l]  <= nq0_next[l];
                den_reg[0][l] <= den_next[l];
                neg_reg[0][l] <= neg_next[l];
            end
            for (int k = 0; k < DIV_STEPS; k++) begin
                for (int l = 0; l < LANES; l++) begin
                    rem_reg[k+1][l] <= rem_next[k][l];
                    nq_reg[k+1][l]  <= nq_next[k][l];
                    den_reg[k+1][l] <= den_reg[k][l];
                    neg_reg[k+1][l] <= neg_reg[k][l];
                end
            end
        end
    end

    // merge the slab intervals; parallel axes leave near and far alone
    always_comb begin
        near_next = '0;
        far_next  = Q_MAX;
        for (int a = 0; a < AXES; a++) begin
            if (!oside_reg.par[a] && tmin_reg[a] > near_next) begin
                near_next = tmin_reg[a];
            end
        end
        for (int a = 0; a < AXES; a++) begin
            if (!oside_reg.par[a] && tmax_reg[a] < far_next) begin
                far_next = tmax_reg[a];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            for (int l = 0; l < LANES; l++) begin
                t_reg[l] <= sat_quot(nq_reg[DIV_STEPS][l], neg_reg[DIV_STEPS][l]);
            end
            for (int a = 0; a < AXES; a++) begin
                tmin_reg[a] <= (t_reg[a] < t_reg[a+AXES]) ? t_reg[a] : t_reg[a+AXES];
                tmax_reg[a] <= (t_reg[a] < t_reg[a+AXES]) ? t_reg[a+AXES] : t_reg[a];
            end
            near_reg <= near_next;
            far_reg  <= far_next;
        end
    end

    // valid bits and side flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) begin
                side_reg[k] <= '0;
            end
            tside_reg <= '0;
            oside_reg <= '0;
            mside_reg <= '0;
        end else if (ce) begin
            side_reg[0] <= side0_next;
            for (int k = 0; k < DIV_STEPS; k++) begin
                side_reg[k+1] <= side_reg[k];
            end
            tside_reg <= side_reg[DIV_STEPS];
            oside_reg <= tside_reg;
            mside_reg <= oside_reg;
        end
    end

    assign res_hit  = !mside_reg.par_miss && (near_reg <= far_reg);
    assign res_dist = res_hit ? near_reg[DIST_W-1:0] : '0;

    // output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (skid_v_reg) begin
            if (m_axis_tready) begin
                skid_v_reg <= 1'b0;
            end
        end else if (mside_reg.valid) begin
            if (out_v_reg && !m_axis_tready) begin
                skid_v_reg <= 1'b1;
            end else begin
                out_v_reg <= 1'b1;
            end
        end else if (m_axis_tready) begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_v_reg) begin
            if (m_axis_tready) begin
                out_hit_reg  <= skid_hit_reg;
                out_dist_reg <= skid_dist_reg;
            end
        end else if (mside_reg.valid) begin
            if (out_v_reg && !m_axis_tready) begin
                skid_hit_reg  <= res_hit;
                skid_dist_reg <= res_dist;
            end else begin
                out_hit_reg  <= res_hit;
                out_dist_reg <= res_dist;
            end
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {{(OUT_W - DIST_W){1'b0}}, out_dist_reg};

`ifndef NO_ASSERTIONS
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid stage holds an item while output is empty");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("missed test carries a nonzero distance");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> (!m_axis_tvalid && !skid_v_reg))
        else $error("output valid right after reset");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_v_reg && m_axis_tready) |=> (m_axis_tvalid && !skid_v_reg))
        else $error("skid item lost on drain");
`endif

endmodule

// ===== tb/tb_ray_box_slab_test.sv =====
`timescale 1ns / 1ps

module tb_ray_box_slab_test;
    import rbst_pkg::*;

    typedef struct packed {
        logic        hit;
        logic [30:0] distance;
    } slab_res_t;

    logic              aclk;
    logic              aresetn;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;

    slab_res_t expected_hits[$];
    int        err_count;
    bit        gaps_on;

    ray_box_slab_test dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // saturated (num * 2^16) / den, truncated toward zero
    function automatic longint slab_quot(longint num, longint den);
        longint q;
        q = (num * 65536) / den;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        return q;
    endfunction

    function automatic slab_res_t predict_slab(logic [IN_W-1:0] ray);
        slab_res_t r;
        longint near_t, far_t, o, d, lo, hi, t1, t2, tmp;
        bit ok;
        near_t = 0;
        far_t = 64'sd2147483647;
        ok = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (ok) begin
                o  = longint'($signed(ray[(F_ORIGIN+a)*QW +: QW]));
                d  = longint'($signed(ray[(F_DIR+a)*QW +: QW]));
                lo = longint'($signed(ray[(F_MIN+a)*QW +: QW]));
                hi = longint'($signed(ray[(F_MAX+a)*QW +: QW]));
                if (d == 0) begin
                    if (o < lo || o > hi) ok = 1'b0;
                end else begin
                    t1 = slab_quot(lo - o, d);
                    t2 = slab_quot(hi - o, d);
                    if (t1 > t2) begin
                        tmp = t1; t1 = t2; t2 = tmp;
                    end
                    if (t1 > near_t) near_t = t1;
                    if (t2 < far_t) far_t = t2;
                    if (near_t > far_t) ok = 1'b0;
                end
            end
        end
        r.hit      = ok;
        r.distance = ok ? near_t[30:0] : 31'd0;
        return r;
    endfunction

    // leave tvalid high after the accept; the next item or the caller drops it
    task automatic send_ray(logic [IN_W-1:0] ray);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ray;
        do @(posedge aclk); while (!s_axis_tready);
        expected_hits.push_back(predict_slab(ray));
    endtask

    function automatic logic [IN_W-1:0] pack_ray(q_t o[3], q_t d[3], q_t lo[3], q_t hi[3]);
        logic [IN_W-1:0] v;
        for (int a = 0; a < 3; a++) begin
            v[(F_ORIGIN+a)*QW +: QW] = o[a];
            v[(F_DIR+a)*QW +: QW]    = d[a];
            v[(F_MIN+a)*QW +: QW]    = lo[a];
            v[(F_MAX+a)*QW +: QW]    = hi[a];
        end
        return v;
    endfunction

    function automatic q_t rand_word();
        case ($urandom_range(0, 5))
            0: return q_t'($urandom_range(0, 4)) - 2;
            1: return Q_MAX;
            2: return Q_MIN;
            default: return q_t'($urandom);
        endcase
    endfunction

    // small-magnitude word so slabs overlap often
    function automatic q_t rand_near();
        return q_t'($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            slab_res_t e;
            if (expected_hits.size() == 0) begin
                $error("unexpected result hit=%0b distance=%h", m_axis_tuser, m_axis_tdata);
                err_count++;
            end else begin
                e = expected_hits.pop_front();
                if (m_axis_tuser !== e.hit) begin
                    $error("hit: expected %0b actual %0b", e.hit, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tdata !== {1'b0, e.distance}) begin
                    $error("entry_distance: expected %h actual %h", e.distance, m_axis_tdata);
                    err_count++;
                end
            end
        end
    end

    initial begin
        m_axis_tready = 1'b0;
        @(posedge aclk);
        forever begin
            if (gaps_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic wait_drained();
        while (expected_hits.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed();
        q_t o[3], d[3], lo[3], hi[3];
        for (int a = 0; a < 3; a++) begin
            o[a] = 0; d[a] = 32'sh0001_0000; lo[a] = 32'sh0001_0000; hi[a] = 32'sh0002_0000;
        end
        send_ray(pack_ray(o, d, lo, hi));
        d[1] = 0; d[2] = 0; lo[1] = -1; hi[1] = 1; lo[2] = 0; hi[2] = 0;
        send_ray(pack_ray(o, d, lo, hi));          // parallel, inside
        o[1] = 2;
        send_ray(pack_ray(o, d, lo, hi));          // parallel, above max
        o[1] = -2;
        send_ray(pack_ray(o, d, lo, hi));          // parallel, below min
        o[1] = 0; lo[2] = 1; hi[2] = -1;
        send_ray(pack_ray(o, d, lo, hi));          // inverted box on parallel axis
        for (int a = 0; a < 3; a++) begin
            o[a] = 0; d[a] = -32'sh0001_0000; lo[a] = 32'sh0002_0000; hi[a] = -32'sh0002_0000;
        end
        send_ray(pack_ray(o, d, lo, hi));          // inverted box, moving axes
        for (int a = 0; a < 3; a++) begin
            lo[a] = -32'sh0001_0000; hi[a] = 32'sh0001_0000;
        end
        send_ray(pack_ray(o, d, lo, hi));          // origin inside
        for (int a = 0; a < 3; a++) begin
            o[a] = Q_MIN; d[a] = 1; lo[a] = Q_MIN; hi[a] = Q_MAX;
        end
        send_ray(pack_ray(o, d, lo, hi));          // saturating quotient
        for (int a = 0; a < 3; a++) begin
            o[a] = Q_MAX; d[a] = Q_MIN; lo[a] = Q_MIN; hi[a] = Q_MAX;
        end
        send_ray(pack_ray(o, d, lo, hi));
        for (int a = 0; a < 3; a++) begin
            o[a] = Q_MAX; d[a] = Q_MAX; lo[a] = Q_MIN; hi[a] = Q_MIN;
        end
        send_ray(pack_ray(o, d, lo, hi));
        // near equals far: touch at one point
        for (int a = 0; a < 3; a++) begin
            o[a] = 0; d[a] = 32'sh0001_0000; lo[a] = 32'sh0003_0000; hi[a] = 32'sh0004_0000;
        end
        lo[1] = 32'sh0004_0000; hi[1] = 32'sh0005_0000;
        send_ray(pack_ray(o, d, lo, hi));
        lo[1] = 32'sh0004_0001;
        send_ray(pack_ray(o, d, lo, hi));          // just misses
        // tiny direction, one step
        for (int a = 0; a < 3; a++) begin
            o[a] = 0; d[a] = 1; lo[a] = -1; hi[a] = 1;
        end
        send_ray(pack_ray(o, d, lo, hi));
        send_ray('0);
        send_ray('1);
    endtask

    task automatic test_random(int count, bit noisy);
        q_t o[3], d[3], lo[3], hi[3];
        for (int i = 0; i < count; i++) begin
            for (int a = 0; a < 3; a++) begin
                if (noisy || $urandom_range(0, 4) == 0) begin
                    o[a] = rand_word(); d[a] = rand_word();
                    lo[a] = rand_word(); hi[a] = rand_word();
                end else begin
                    o[a]  = rand_near();
                    d[a]  = ($urandom_range(0, 6) == 0) ? q_t'(0) : rand_near();
                    lo[a] = rand_near();
                    hi[a] = lo[a] + q_t'($urandom_range(0, 32'h0004_0000));
                end
            end
            send_ray(pack_ray(o, d, lo, hi));
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        err_count     = 0;
        gaps_on       = 1'b1;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(250, 1'b1);
        s_axis_tvalid <= 1'b0;
        wait_drained();             // hold off until the pipeline is empty
        test_random(350, 1'b0);
        gaps_on = 1'b0;
        test_random(150, 1'b0);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (80) @(posedge aclk);
        if (err_count == 0 && expected_hits.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
